/* sv/lbpr_pkg.sv */
// Shared types, constants and helpers for the 3x3 local binary pattern block.
// Used by the channel interfaces, the line memory and the top level.
package lbpr_pkg;

   localparam int PIX_W = 8;
   localparam int CODE_W = 8;
   localparam int LINE_LANES = 3;
   localparam int LANE_W = 2;

   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;

   localparam int WIDTH_RESET = 640;
   localparam int HEIGHT_RESET = 480;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [LANE_W-1:0] lane_type;
   typedef logic [LINE_LANES-1:0][PIX_W-1:0] line_word_type;

   // step a modulo-3 counter
   function automatic logic [1:0] next_mod3(input logic [1:0] v);
      return (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   function automatic logic [1:0] prev_mod3(input logic [1:0] v);
      return (v == 2'd0) ? 2'd2 : v - 2'd1;
   endfunction

endpackage

/* sv/lbpr_req_if.sv */
// Input channel of the LBP block: valid/ready with opcode and pixel payload.
// Depends on lbpr_pkg.
interface lbpr_req_if;
   logic valid;
   logic ready;
   logic opcode;
   lbpr_pkg::pixel_type pixel_value;

   modport source (output valid, output opcode, output pixel_value, input ready);
   modport sink (input valid, input opcode, input pixel_value, output ready);
endinterface

/* sv/lbpr_rsp_if.sv */
// Result channel of the LBP block: valid/ready with code and frame-end flag.
// Depends on lbpr_pkg.
interface lbpr_rsp_if;
   logic valid;
   logic ready;
   lbpr_pkg::code_type lbp_code;
   logic last_of_frame;

   modport source (output valid, output lbp_code, output last_of_frame, input ready);
   modport sink (input valid, input lbp_code, input last_of_frame, output ready);
endinterface

/* sv/lbp_3x3_replicated_border.sv */
// Top level of the streaming 3x3 LBP block with replicated borders.
// Depends on lbpr_pkg, lbpr_req_if, lbpr_rsp_if and lbpr_line_mem.
//
//   channel  | direction | handshake     | payload
//   req_chan | in        | valid/ready   | opcode, pixel_value
//   rsp_chan | out       | valid/ready   | lbp_code, last_of_frame
//   csr_*    | in        | csr_wr_en     | csr_index, csr_wr_data
//
// One item per cycle while req_chan.ready is high; a code that an item releases passes
// the registered read of the line memory and then the result queue on its way to rsp_chan.
// Reset clears all counters and loads 640 x 480, clamped to the maximum size; the line memory is not cleared.
// req_chan.ready drops when the three-entry result queue plus the code in flight is full.
module lbp_3x3_replicated_border #(
   parameter int MAX_WIDTH = lbpr_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lbpr_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lbpr_req_if.sink                          req_chan,
   lbpr_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [lbpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbpr_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int RST_WIDTH =
      (lbpr_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : lbpr_pkg::WIDTH_RESET;
   localparam int RST_HEIGHT =
      (lbpr_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : lbpr_pkg::HEIGHT_RESET;
   localparam logic [COL_W-1:0] RST_COL_LAST = COL_W'(RST_WIDTH - 1);
   localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(RST_HEIGHT - 1);
   localparam logic [2:0] QUEUE_DEPTH = 3'd3;
   localparam int WIDTH_W_LOCAL = lbpr_pkg::WIDTH_REG_W;

   // frame geometry
   logic [COL_W-1:0] col_last_ff, col_last_in;
   logic [ROW_W-1:0] row_last_ff, row_last_in;

   // input and output raster positions
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   lbpr_pkg::lane_type in_lane_ff, in_lane_in;
   logic in_done_ff, in_done_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   lbpr_pkg::lane_type out_lane_ff, out_lane_in;

   // read stage
   logic b_emit_ff, b_emit_in;
   logic b_last_ff;
   logic b_first_ff;
   lbpr_pkg::lane_type b_lane_ff [3];
   logic [2:0] b_fwd_c_ff;
   logic [2:0] b_fwd_r_ff;
   lbpr_pkg::pixel_type b_px_ff;
   lbpr_pkg::pixel_type win_mid_ff [3];

   // result queue
   lbpr_pkg::code_type q_code_ff [3];
   logic q_last_ff [3];
   logic [1:0] q_wptr_ff, q_wptr_in;
   logic [1:0] q_rptr_ff, q_rptr_in;
   logic [1:0] q_count_ff, q_count_in;

   logic accept, take, emit_a, last_a, rdy;
   logic col_wrap, row_wrap, out_col_end, out_row_end;
   logic [COL_W-1:0] nc;
   logic [ROW_W-1:0] nr;
   logic [ROW_W-1:0] row_a [3];
   lbpr_pkg::lane_type lane_a [3];
   logic [2:0] fwd_c, fwd_r;
   logic [2:0] pending;
   logic pop;
   logic [WIDTH_W_LOCAL-1:0] csr_w_val;
   logic [lbpr_pkg::HEIGHT_REG_W-1:0] csr_h_val;

   lbpr_pkg::line_word_type rd_a, rd_b;
   lbpr_pkg::pixel_type mid_col [3];
   lbpr_pkg::pixel_type left_col [3];
   lbpr_pkg::pixel_type right_col [3];
   lbpr_pkg::code_type code_b;

   assign pending = 3'(q_count_ff) + 3'(b_emit_ff);
   assign req_chan.ready = pending < QUEUE_DEPTH;
   assign accept = req_chan.valid && req_chan.ready;
   assign take = accept && (req_chan.opcode == lbpr_pkg::OP_PIXEL) && !in_done_ff;

   assign col_wrap = in_col_ff == col_last_ff;
   assign row_wrap = in_row_ff == row_last_ff;
   assign out_col_end = out_col_ff == col_last_ff;
   assign out_row_end = out_row_ff == row_last_ff;
   assign nc = out_col_end ? out_col_ff : out_col_ff + 1'b1;
   assign nr = out_row_end ? out_row_ff : out_row_ff + 1'b1;
   assign last_a = out_row_end && out_col_end;

   // position after this item's pixel
   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_lane_in = in_lane_ff;
      in_done_in = in_done_ff;
      if (take) begin
         if (col_wrap) begin
            in_col_in = '0;
            if (row_wrap) begin
               in_row_in = '0;
               in_lane_in = '0;
               in_done_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + 1'b1;
               in_lane_in = lbpr_pkg::next_mod3(in_lane_ff);
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   assign rdy = in_done_in || (nr < in_row_in) || ((nr == in_row_in) && (nc < in_col_in));
   assign emit_a = accept && rdy;

   // neighborhood rows with their lanes, top to bottom
   always_comb begin
      row_a[0] = (out_row_ff == '0) ? '0 : out_row_ff - 1'b1;
      lane_a[0] = (out_row_ff == '0) ? '0 : lbpr_pkg::prev_mod3(out_lane_ff);
      row_a[1] = out_row_ff;
      lane_a[1] = out_lane_ff;
      row_a[2] = nr;
      lane_a[2] = out_row_end ? out_lane_ff : lbpr_pkg::next_mod3(out_lane_ff);
      for (int k = 0; k < 3; k++) begin
         fwd_c[k] = take && (row_a[k] == in_row_ff) && (out_col_ff == in_col_ff);
         fwd_r[k] = take && (row_a[k] == in_row_ff) && (nc == in_col_ff);
      end
   end

   assign csr_w_val = csr_wr_data[WIDTH_W_LOCAL-1:0];
   assign csr_h_val = csr_wr_data[lbpr_pkg::HEIGHT_REG_W-1:0];

   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_lane_in = out_lane_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lbpr_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_w_val == '0) begin
                  col_last_in = '0;
               end else if (int'(csr_w_val) > MAX_WIDTH) begin
                  col_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  col_last_in = COL_W'(csr_w_val - 1'b1);
               end
            end
            lbpr_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_h_val == '0) begin
                  row_last_in = '0;
               end else if (int'(csr_h_val) > MAX_HEIGHT) begin
                  row_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  row_last_in = ROW_W'(csr_h_val - 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
      if (emit_a && !last_a) begin
         if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
            out_lane_in = lbpr_pkg::next_mod3(out_lane_ff);
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= RST_COL_LAST;
         row_last_ff <= RST_ROW_LAST;
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_lane_ff <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_lane_ff <= '0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         // restart the frame on a register write or after its last code
         if (csr_wr_en || (emit_a && last_a)) begin
            in_col_ff <= '0;
            in_row_ff <= '0;
            in_lane_ff <= '0;
            in_done_ff <= 1'b0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            out_lane_ff <= '0;
         end else begin
            in_col_ff <= in_col_in;
            in_row_ff <= in_row_in;
            in_lane_ff <= in_lane_in;
            in_done_ff <= in_done_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
            out_lane_ff <= out_lane_in;
         end
      end
   end

   lbpr_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock     (clock),
      .wr_en     (take),
      .wr_addr   (in_col_ff),
      .wr_lane   (in_lane_ff),
      .wr_data   (req_chan.pixel_value),
      .rd_en     (emit_a),
      .rd_addr_a (out_col_ff),
      .rd_addr_b (nc),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign b_emit_in = emit_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_emit_ff <= 1'b0;
      end else begin
         b_emit_ff <= b_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_a) begin
         b_last_ff <= last_a;
         b_first_ff <= out_col_ff == '0;
         b_fwd_c_ff <= fwd_c;
         b_fwd_r_ff <= fwd_r;
         b_px_ff <= req_chan.pixel_value;
         for (int k = 0; k < 3; k++) begin
            b_lane_ff[k] <= lane_a[k];
         end
      end
      if (b_emit_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_mid_ff[k] <= mid_col[k];
         end
      end
   end

   // assemble the window: forward this item's pixel over stale memory data
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mid_col[k] = b_fwd_c_ff[k] ? b_px_ff : rd_a[b_lane_ff[k]];
         right_col[k] = b_fwd_r_ff[k] ? b_px_ff : rd_b[b_lane_ff[k]];
         left_col[k] = b_first_ff ? mid_col[k] : win_mid_ff[k];
      end
      code_b = {mid_col[1] <= mid_col[0],
                mid_col[1] <= left_col[0],
                mid_col[1] <= left_col[1],
                mid_col[1] <= left_col[2],
                mid_col[1] <= mid_col[2],
                mid_col[1] <= right_col[2],
                mid_col[1] <= right_col[1],
                mid_col[1] <= right_col[0]};
   end

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      q_wptr_in = b_emit_ff ? lbpr_pkg::next_mod3(q_wptr_ff) : q_wptr_ff;
      q_rptr_in = pop ? lbpr_pkg::next_mod3(q_rptr_ff) : q_rptr_ff;
      q_count_in = q_count_ff;
      priority if (b_emit_ff && !pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (pop && !b_emit_ff) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wptr_ff <= '0;
         q_rptr_ff <= '0;
         q_count_ff <= '0;
      end else begin
         q_wptr_ff <= q_wptr_in;
         q_rptr_ff <= q_rptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_emit_ff) begin
         q_code_ff[q_wptr_ff] <= code_b;
         q_last_ff[q_wptr_ff] <= b_last_ff;
      end
   end

   assign rsp_chan.valid = q_count_ff != '0;
   assign rsp_chan.lbp_code = q_code_ff[q_rptr_ff];
   assign rsp_chan.last_of_frame = q_last_ff[q_rptr_ff];

endmodule

/* sv/lbpr_line_mem.sv */
// Line memory: one word per column, one byte lane per frame row modulo 3.
// Byte-lane write, two registered read ports, read-before-write. Uses lbpr_pkg.
module lbpr_line_mem #(
   parameter int DEPTH = lbpr_pkg::MAX_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  lbpr_pkg::lane_type                         wr_lane,
   input  lbpr_pkg::pixel_type                        wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output lbpr_pkg::line_word_type                    rd_data_a,
   output lbpr_pkg::line_word_type                    rd_data_b
);
   lbpr_pkg::line_word_type mem [DEPTH];
   lbpr_pkg::line_word_type rd_a_ff;
   lbpr_pkg::line_word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][wr_lane] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
